FILE: rtl/wrt_pkg.sv
package wrt_pkg;

    localparam int POSITION_BITS_DEF = 24;
    localparam int MAX_WINDOWS_DEF   = 256;

    localparam int SAMPLE_W = 16;
    localparam int SQ_W     = 31;
    localparam int SUM_W    = 46;
    localparam int CNT_W    = 16;
    localparam int WLEN_W   = 16;
    localparam int WCNT_W   = 9;
    localparam int FS_W     = 24;
    localparam int FE_W     = 25;
    localparam int THR_W    = 15;
    localparam int IDX_W    = 8;

    localparam int CFG_W     = 25;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_START   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END     = 2'd3;

    localparam logic [WLEN_W-1:0] WLEN_RST   = 16'd64;
    localparam logic [WCNT_W-1:0] WCNT_RST   = 9'd8;
    localparam logic [FS_W-1:0]   FSTART_RST = 24'd0;
    localparam logic [FE_W-1:0]   FEND_RST   = 25'h1000000;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_LVL_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       vector_start;
    } t_in;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [IDX_W-1:0] window_index;
        logic             window_empty;
        logic             last_window;
    } t_out;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] index;
        logic             last;
    } t_job;

    typedef struct packed {
        logic               empty;
        logic [Q_LVL_W-1:0] level;
    } t_q_stat;

endpackage

FILE: rtl/windowed_rms_threshold_unit.sv
// Windowed RMS threshold unit.
// Input channel (i_in_valid/o_in_ready, i_in_data): one signed sample per
// transaction; vector_start marks position zero of a new vector.
// Output channel (o_out_valid/i_out_ready, o_out_data): one threshold per
// completed window, with its index, an empty flag and a last-window flag.
// Config port (i_cfg_we, i_cfg_idx, i_cfg_data): write while idle.
// Samples are taken one per cycle while the job queue (4 entries) has at
// least two free slots. The sample path squares and accumulates in two
// stages; each finished window becomes one job.
// The back end runs one job at a time: queue read, restoring divide,
// bit-serial square root, output register load; an empty window skips the
// divide and the root. It takes the next job from the queue only after the
// current one has loaded the output register.
// Reset restores register defaults, clears the vector state and the queue.
// When the receiver stalls, the result holds in the output register, the back
// end finishes one more job and waits, and the queue fills until the input
// channel deasserts ready.
module windowed_rms_threshold_unit import wrt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int MAX_WINDOWS   = MAX_WINDOWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic    push, pop;
    t_job    push_job, pop_job;
    t_q_stat q_stat;

    wrt_front #(
        .POSITION_BITS(POSITION_BITS),
        .MAX_WINDOWS  (MAX_WINDOWS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_job      (push_job)
    );

    wrt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_q_stat (q_stat)
    );

    wrt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .i_job       (pop_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

FILE: rtl/wrt_front.sv
module wrt_front import wrt_pkg::*; #(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int MAX_WINDOWS   = MAX_WINDOWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_q_stat              i_q_stat,
    output logic                 o_push,
    output t_job                 o_job
);

    localparam int CMP_W = (POSITION_BITS > FE_W) ? POSITION_BITS : FE_W;

    logic [WLEN_W-1:0]        r_wlen;
    logic [WCNT_W-1:0]        r_wcnt;
    logic [FS_W-1:0]          r_fstart;
    logic [FE_W-1:0]          r_fend;

    logic [POSITION_BITS-1:0] r_pos, n_pos, pos0;
    logic [WCNT_W-1:0]        r_wn, n_wn, wn0;
    logic [WLEN_W-1:0]        r_off, n_off, off0, off1;
    logic [CNT_W-1:0]         r_cnt, n_cnt, cnt0, cnt1;

    logic                     r_b_vld, r_b_clr, r_b_add, r_b_end, r_b_last;
    logic [SQ_W-1:0]          r_b_sq;
    logic [CNT_W-1:0]         r_b_cnt;
    logic [IDX_W-1:0]         r_b_idx;
    logic [SUM_W-1:0]         r_sum, tot, base;

    logic                     acc, clr, active, in_frame, add, win_end, last;
    logic [WCNT_W-1:0]        wc;
    logic signed [2*SAMPLE_W-1:0] sq_full;

    assign o_in_ready = (i_q_stat.level <= Q_LVL_W'(Q_DEPTH - 2));
    assign acc        = i_in_valid && o_in_ready;
    assign sq_full    = (2*SAMPLE_W)'(i_in_data.sample) * (2*SAMPLE_W)'(i_in_data.sample);

    always_comb begin
        wc   = (int'(r_wcnt) > MAX_WINDOWS) ? WCNT_W'(MAX_WINDOWS) : r_wcnt;
        clr  = i_in_data.vector_start;
        pos0 = clr ? '0 : r_pos;
        wn0  = clr ? '0 : r_wn;
        off0 = clr ? '0 : r_off;
        cnt0 = clr ? '0 : r_cnt;

        active   = (r_wlen != '0) && (wn0 < wc);
        in_frame = (CMP_W'(pos0) >= CMP_W'(r_fstart)) && (CMP_W'(pos0) < CMP_W'(r_fend));
        add      = active && in_frame;
        cnt1     = cnt0 + CNT_W'(add);
        off1     = off0 + 1'b1;
        win_end  = active && ((off1 >= r_wlen) || (off1 == '0));
        last     = ((wn0 + 1'b1) == wc);

        n_pos = active ? pos0 + 1'b1 : pos0;
        n_wn  = win_end ? wn0 + 1'b1 : wn0;
        n_off = off0;
        n_cnt = cnt0;
        if (active) begin
            n_off = win_end ? '0 : off1;
            n_cnt = win_end ? '0 : cnt1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen   <= WLEN_RST;
            r_wcnt   <= WCNT_RST;
            r_fstart <= FSTART_RST;
            r_fend   <= FEND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_WINDOW_LENGTH: r_wlen   <= i_cfg_data[WLEN_W-1:0];
                REG_WINDOW_COUNT:  r_wcnt   <= i_cfg_data[WCNT_W-1:0];
                REG_FRAME_START:   r_fstart <= i_cfg_data[FS_W-1:0];
                REG_FRAME_END:     r_fend   <= i_cfg_data[FE_W-1:0];
                default:           r_wlen   <= r_wlen;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_wn    <= '0;
            r_off   <= '0;
            r_cnt   <= '0;
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= acc;
            if (acc) begin
                r_pos <= n_pos;
                r_wn  <= n_wn;
                r_off <= n_off;
                r_cnt <= n_cnt;
            end
        end
    end

    // square stage payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_clr  <= clr;
            r_b_add  <= add;
            r_b_end  <= win_end;
            r_b_sq   <= sq_full[SQ_W-1:0];
            r_b_cnt  <= cnt1;
            r_b_idx  <= wn0[IDX_W-1:0];
            r_b_last <= last;
        end
    end

    assign base = r_b_clr ? '0 : r_sum;
    assign tot  = base + (r_b_add ? SUM_W'(r_b_sq) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (r_b_vld) begin
            r_sum <= r_b_end ? '0 : tot;
        end
    end

    assign o_push      = r_b_vld && r_b_end;
    assign o_job.sum   = tot;
    assign o_job.count = r_b_cnt;
    assign o_job.index = r_b_idx;
    assign o_job.last  = r_b_last;

endmodule

FILE: rtl/wrt_queue.sv
module wrt_queue import wrt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_q_stat
);

    t_job               r_mem [Q_DEPTH];
    t_job               r_rd_data;
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_LVL_W-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            r_level <= r_level + Q_LVL_W'(i_push) - Q_LVL_W'(i_pop);
        end
    end

    assign o_job          = r_rd_data;
    assign o_q_stat.empty = (r_level == '0);
    assign o_q_stat.level = r_level;

endmodule

FILE: rtl/wrt_back.sv
module wrt_back import wrt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_stat i_q_stat,
    output logic    o_pop,
    input  t_job    i_job,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out_data
);

    localparam int IT_W     = $clog2(SUM_W);
    localparam int BIT_TOP  = 2 * ((SUM_W / 2) - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_HOLD = 3'd4;

    logic [2:0]       r_state;
    logic [IT_W-1:0]  r_it;
    logic [CNT_W:0]   r_rem;
    logic [CNT_W-1:0] r_div;
    logic [SUM_W-1:0] r_quo, r_res, r_bit;
    logic [IDX_W-1:0] r_idx;
    logic             r_last, r_empty;
    logic             r_out_vld;
    t_out             r_out;

    logic [CNT_W:0]   rem_sh;
    logic             rem_ge;
    logic [SUM_W-1:0] trial;
    logic             sq_ge;
    logic [THR_W-1:0] thr;
    logic             out_load;

    assign rem_sh   = {r_rem[CNT_W-1:0], r_quo[SUM_W-1]};
    assign rem_ge   = (rem_sh >= {1'b0, r_div});
    assign trial    = r_res + r_bit;
    assign sq_ge    = (r_quo >= trial);
    assign thr      = (|r_res[SUM_W-1:THR_W]) ? '1 : r_res[THR_W-1:0];
    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign out_load = (r_state == S_HOLD) && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (o_pop) r_state <= S_LOAD;
                S_LOAD: r_state <= (i_job.count == '0) ? S_HOLD : S_DIV;
                S_DIV:  if (r_it == IT_W'(SUM_W - 1)) r_state <= S_SQRT;
                S_SQRT: if (r_bit[0]) r_state <= S_HOLD;
                S_HOLD: if (out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_LOAD: begin
                r_quo   <= i_job.sum;
                r_div   <= i_job.count;
                r_idx   <= i_job.index;
                r_last  <= i_job.last;
                r_empty <= (i_job.count == '0);
                r_rem   <= '0;
                r_res   <= '0;
                r_it    <= '0;
                r_bit   <= SUM_W'(1) << BIT_TOP;
            end
            S_DIV: begin
                r_rem <= rem_ge ? rem_sh - {1'b0, r_div} : rem_sh;
                r_quo <= {r_quo[SUM_W-2:0], rem_ge};
                r_it  <= r_it + 1'b1;
            end
            S_SQRT: begin
                if (sq_ge) begin
                    r_quo <= r_quo - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_HOLD: begin
                if (out_load) begin
                    r_out.threshold    <= thr;
                    r_out.window_index <= r_idx;
                    r_out.window_empty <= r_empty;
                    r_out.last_window  <= r_last;
                end
            end
            default: r_it <= r_it;
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/wrt_checker.sv
module wrt_checker import wrt_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transaction");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("output payload changed while stalled");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.window_empty |-> i_out_data.threshold == '0)
        else $error("empty window with nonzero threshold");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("output valid or input stall right after reset");

endmodule

bind windowed_rms_threshold_unit wrt_checker u_wrt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out_data  (o_out_data)
);
